FILE: hdl/wtss_pkg.sv
package wtss_pkg;

  localparam int unsigned NumDays     = 7;
  localparam int unsigned SlotsPerDay = 2;
  localparam int unsigned WordW       = 16;
  localparam int unsigned DayW        = 3;
  localparam int unsigned HourW       = 5;
  localparam int unsigned MinuteW     = 6;
  localparam int unsigned IndexW      = 4;
  localparam int unsigned CfgDataW    = 7;

  // schedule word layout
  localparam int unsigned OnOffBit = 15;
  localparam int unsigned HourMsb  = 12;
  localparam int unsigned HourLsb  = 8;
  localparam int unsigned MinMsb   = 7;
  localparam int unsigned MinLsb   = 0;
  localparam int unsigned SchedMinW = MinMsb - MinLsb + 1;

  typedef enum logic [0:0] {
    ModeTick  = 1'b0,
    ModeWrite = 1'b1
  } mode_e;

  typedef enum logic [0:0] {
    CfgMasterEnable  = 1'b0,
    CfgDayEnableMask = 1'b1
  } cfg_idx_e;

  typedef logic [SlotsPerDay-1:0][WordW-1:0] sched_row_t;

  typedef struct packed {
    mode_e              mode;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [IndexW-1:0]  entry_index;
    logic [WordW-1:0]   entry_value;
  } in_t;

  typedef struct packed {
    logic                   switch_valid;
    logic                   switch_on;
    logic [SlotsPerDay-1:0] slots_fired;
  } out_t;

endpackage

FILE: hdl/weekly_two_slot_switch_scheduler_top.sv
// channel   | handshake                   | payload
// ----------+-----------------------------+---------------------------------
// in        | in_valid_i / in_stall_o     | in_data_i  (tick or word write)
// out       | out_valid_o / out_stall_i   | out_data_o (one result per beat)
// cfg       | cfg_we_i, cfg_idx_i         | cfg_wdata_i (no read-back)
//
// one beat in per cycle unless in_stall_o is high: input register,
// then slot compare and flag update in a single pass into the result register
// schedule words and done flags sit in flops, one row of two words per day,
// so a single row read serves both a tick and a word write
// async active-low reset clears schedule, flags, enables and both valid bits
// a stall on the output holds the result and, through it, the input register
module weekly_two_slot_switch_scheduler_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  wtss_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output wtss_pkg::out_t             out_data_o,
  input  logic                       cfg_we_i,
  input  wtss_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [wtss_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import wtss_pkg::*;

  localparam logic [DayW-1:0] LastRow = DayW'(NumDays - 1);

  // configuration
  logic                master_en_q;
  logic [NumDays-1:0]  day_mask_q;

  // schedule state, one row per day
  sched_row_t [NumDays-1:0]                 words_q, words_d;
  logic [NumDays-1:0][SlotsPerDay-1:0]      done_q, done_d;

  // pipeline
  logic  in_valid_q;
  in_t   in_q;
  logic  out_valid_q;
  out_t  out_q;
  out_t  res;
  logic  advance;

  // combinational helpers
  logic [DayW-1:0]        rd_row;
  logic [DayW-1:0]        prev_row;
  logic                   idx_ok;
  logic                   day_ok;
  sched_row_t             row;
  logic [HourW-1:0]       slot_hour;
  logic [SchedMinW-1:0]   slot_min;
  logic [SchedMinW-1:0]   cur_min;
  logic [SlotsPerDay-1:0] cur_done;

  // the result register frees up when empty or when its beat is taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  assign idx_ok   = in_q.entry_index < IndexW'(NumDays * SlotsPerDay);
  assign day_ok   = in_q.day != '0;
  assign prev_row = (in_q.day == DayW'(1)) ? LastRow : in_q.day - DayW'(2);
  assign cur_min  = SchedMinW'(in_q.minute);

  always_comb begin
    // one row address serves both beat kinds
    if (in_q.mode == ModeWrite) begin
      rd_row = idx_ok ? in_q.entry_index[IndexW-1:1] : '0;
    end else begin
      rd_row = day_ok ? in_q.day - DayW'(1) : '0;
    end
  end

  assign row = words_q[rd_row];

  always_comb begin
    words_d   = words_q;
    done_d    = done_q;
    res       = '0;
    cur_done  = '0;
    slot_hour = '0;
    slot_min  = '0;
    if (in_valid_q && advance) begin
      if (in_q.mode == ModeWrite) begin
        if (idx_ok) begin
          // a changed word may fire again
          if (row[in_q.entry_index[0]] != in_q.entry_value) begin
            done_d[rd_row][in_q.entry_index[0]] = 1'b0;
          end
          words_d[rd_row][in_q.entry_index[0]] = in_q.entry_value;
        end
      end else if (master_en_q && day_ok) begin
        done_d[prev_row] = '0;
        cur_done         = done_q[rd_row];
        if (day_mask_q[rd_row]) begin
          for (int s = 0; s < SlotsPerDay; s++) begin
            slot_hour = row[s][HourMsb:HourLsb];
            slot_min  = row[s][MinMsb:MinLsb];
            if (!cur_done[s] &&
                ((in_q.hour == slot_hour && cur_min >= slot_min) ||
                 in_q.hour > slot_hour)) begin
              // later slot wins the switch command
              res.switch_on      = row[s][OnOffBit];
              res.switch_valid   = 1'b1;
              res.slots_fired[s] = 1'b1;
              done_d[rd_row][s]  = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_en_q <= 1'b0;
      day_mask_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMasterEnable:  master_en_q <= cfg_wdata_i[0];
        CfgDayEnableMask: day_mask_q  <= cfg_wdata_i[NumDays-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
      done_q  <= '0;
    end else begin
      words_q <= words_d;
      done_q  <= done_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
